// ----- hw/rtl/wspe_pkg.sv -----
// ----------------------------------------------------------------------------
// wspe_pkg: shared types and constants of the shortest path engine
// Sizes, request and status codes, cell control and record structs.
// ----------------------------------------------------------------------------
package wspe_pkg;

  localparam int VERTEX_SLOTS = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VIDX_W       = 6;
  localparam int VCNT_W       = 7;
  localparam int EADDR_W      = 8;
  localparam int ECNT_W       = 9;
  localparam int DIST_W       = 32;
  localparam int EDGE_W       = 62;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_START = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_END   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] CFG_FARE_WEIGHT  = 2'd1;
  localparam logic [1:0] CFG_BIKE_ALLOWED = 2'd2;

  typedef struct packed {
    logic [VIDX_W-1:0] from_v;
    logic [VIDX_W-1:0] to_v;
    logic              transfer;
    logic [15:0]       time_v;
    logic [16:0]       bike;
    logic [15:0]       fare;
  } edge_rec_t;

  // minimum search token, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [DIST_W-1:0] plen;
    logic [VIDX_W-1:0] idx;
  } token_t;

  // broadcast control to all cells
  typedef struct packed {
    logic              init;
    logic [VIDX_W-1:0] start;
    logic              settle_v;
    logic [VIDX_W-1:0] settle_idx;
    logic              relax_v;
    logic [VIDX_W-1:0] relax_to;
    logic [VIDX_W-1:0] relax_from;
    logic [DIST_W-1:0] relax_cand;
  } cell_ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] plen;
    logic              reached;
    logic              pv;
    logic [VIDX_W-1:0] prev;
  } cell_rec_t;

endpackage

// ----- hw/rtl/wspe_ram.sv -----
// ----------------------------------------------------------------------------
// wspe_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/wspe_cell.sv -----
// ----------------------------------------------------------------------------
// wspe_cell: one vertex cell
// Holds distance, predecessor and settled flag of one vertex, relaxes on
// the broadcast bus and passes the minimum search token to its neighbor.
// ----------------------------------------------------------------------------
module wspe_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [wspe_pkg::VIDX_W-1:0] idx,
  input  logic                       active,
  input  wspe_pkg::cell_ctl_t        ctl,
  input  wspe_pkg::token_t           tok_in,
  output wspe_pkg::token_t           tok_out,
  output wspe_pkg::cell_rec_t        rec
);
  import wspe_pkg::*;

  logic settled;
  logic take;
  logic relax_hit;

  assign take = active && rec.reached && !settled &&
                (!tok_in.found || rec.plen < tok_in.plen);
  assign relax_hit = ctl.relax_v && ctl.relax_to == idx &&
                     (!rec.reached || ctl.relax_cand < rec.plen);

  // advance the search token
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (take) begin
      tok_out.found <= 1'b1;
      tok_out.plen  <= rec.plen;
      tok_out.idx   <= idx;
    end else begin
      tok_out.found <= tok_in.found;
      tok_out.plen  <= tok_in.plen;
      tok_out.idx   <= tok_in.idx;
    end
  end

  // init, settle and relax the vertex record
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      rec.plen    <= (idx == ctl.start) ? '0 : DIST_MAX;
      rec.reached <= (idx == ctl.start);
      rec.pv      <= 1'b0;
      rec.prev    <= '0;
      settled     <= 1'b0;
    end else begin
      if (ctl.settle_v && ctl.settle_idx == idx) begin
        settled <= 1'b1;
      end
      if (relax_hit) begin
        rec.plen    <= ctl.relax_cand;
        rec.reached <= 1'b1;
        rec.pv      <= 1'b1;
        rec.prev    <= ctl.relax_from;
      end
    end
  end

endmodule

// ----- hw/rtl/weighted_shortest_path_engine_unit.sv -----
// ----------------------------------------------------------------------------
// weighted_shortest_path_engine_unit: Dijkstra shortest path engine
// Edge store in RAM, a row of vertex cells with a travelling minimum token.
//
//   channel | handshake          | content
//   in      | in_valid/in_ready  | request: clear, add edge, run search
//   out     | out_valid/out_ready| per vertex result or error status
//   cfg     | cfg_we             | vertex_count, fare_weight, bike_allowed
//
// Clear, add and rejected requests are handled in the idle state. A run first
// initialises the cells; then, per settled vertex, the token crosses the cell
// row and the edges are scanned through the RAM read port. A final search
// that finds no vertex starts the result phase, one result per vertex.
// Reset is synchronous; the edge store needs no clearing. A stalled output
// holds the engine in the result phase; new items wait for the run to end.
// ----------------------------------------------------------------------------
module weighted_shortest_path_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [5:0]  from_vertex,
  input  logic [5:0]  dest_vertex,
  input  logic        is_transfer,
  input  logic [15:0] trip_time,
  input  logic [16:0] bike_time,
  input  logic [15:0] fare_hundredths,
  input  logic [5:0]  origin_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  vertex_index,
  output logic [31:0] path_distance,
  output logic        reachable,
  output logic        has_predecessor,
  output logic [5:0]  predecessor,
  output logic [1:0]  status,
  output logic        last
);
  import wspe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_EDGE   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]        state;
  logic [VCNT_W-1:0] vertex_count;
  logic [7:0]        fare_weight;
  logic              bike_allowed;
  logic [ECNT_W-1:0] edge_count;
  logic [VCNT_W-1:0] n_act;
  logic [VIDX_W-1:0] start;
  logic [VIDX_W-1:0] cur;
  logic [DIST_W-1:0] cur_dist;
  logic              inject;
  logic [ECNT_W-1:0] j;
  logic [VIDX_W-1:0] k;
  logic              accept;
  logic              issue;
  logic              v1, v2, v3;
  logic [VIDX_W-1:0] to2, to3;
  logic [DIST_W-1:0] w2, cand3;
  logic [DIST_W:0]   sum;
  logic              match;
  logic [15:0]       eff_t;
  logic [DIST_W-1:0] weight;
  logic              bad_end, full, bad_start;
  logic              err_load, res_load;
  logic [1:0]        err_code;
  logic              search_done;
  logic              edge_done;
  edge_rec_t         wr_edge, rd_edge;
  cell_ctl_t         ctl;
  token_t            chain [VERTEX_SLOTS+1];
  cell_rec_t         recs [VERTEX_SLOTS];
  cell_rec_t         rsel;

  assign n_act = (vertex_count > VCNT_W'(VERTEX_SLOTS)) ? VCNT_W'(VERTEX_SLOTS)
                                                        : vertex_count;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // request checks
  assign bad_end   = ({1'b0, from_vertex} >= n_act) || ({1'b0, dest_vertex} >= n_act);
  assign full      = (edge_count >= ECNT_W'(MAX_EDGES));
  assign bad_start = ({1'b0, origin_vertex} >= n_act);
  always_comb begin
    err_load = 1'b0;
    err_code = ST_OK;
    if (accept) begin
      case (req_type)
        REQ_ADD: begin
          if (bad_end) begin
            err_load = 1'b1;
            err_code = ST_BAD_END;
          end else if (full) begin
            err_load = 1'b1;
            err_code = ST_FULL;
          end
        end
        REQ_RUN: begin
          if (bad_start) begin
            err_load = 1'b1;
            err_code = ST_BAD_START;
          end
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_W'(64);
      fare_weight  <= '0;
      bike_allowed <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[VCNT_W-1:0];
        CFG_FARE_WEIGHT:  fare_weight  <= cfg_data;
        CFG_BIKE_ALLOWED: bike_allowed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // edge store
  assign wr_edge = '{from_v: from_vertex, to_v: dest_vertex, transfer: is_transfer,
                     time_v: trip_time, bike: bike_time, fare: fare_hundredths};

  wspe_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (accept && req_type == REQ_ADD && !bad_end && !full),
    .waddr (edge_count[EADDR_W-1:0]),
    .wdata (wr_edge),
    .raddr (j[EADDR_W-1:0]),
    .rdata (rd_edge)
  );

  // edge scan pipeline: read, weight, candidate
  assign issue = (state == S_EDGE) && (j < edge_count);
  always_comb begin
    eff_t = rd_edge.time_v;
    if (bike_allowed && rd_edge.transfer && !rd_edge.bike[16] &&
        rd_edge.bike[15:0] < rd_edge.time_v) begin
      eff_t = rd_edge.bike[15:0];
    end
  end
  assign weight = DIST_W'(eff_t) * DIST_W'(100) + DIST_W'(fare_weight) * DIST_W'(rd_edge.fare);
  assign match  = v1 && rd_edge.from_v == cur && {1'b0, rd_edge.to_v} < n_act;
  assign sum    = {1'b0, cur_dist} + {1'b0, w2};
  assign edge_done = (state == S_EDGE) && !issue && !v1 && !v2 && !v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= match;
      v3 <= v2;
    end
    w2    <= weight;
    to2   <= rd_edge.to_v;
    to3   <= to2;
    cand3 <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

  // cell row
  assign search_done = (state == S_SEARCH) && chain[VERTEX_SLOTS].valid;
  assign chain[0] = '{valid: inject, found: 1'b0, plen: '0, idx: '0};
  always_comb begin
    ctl.init       = (state == S_INIT);
    ctl.start      = start;
    ctl.settle_v   = search_done && chain[VERTEX_SLOTS].found;
    ctl.settle_idx = chain[VERTEX_SLOTS].idx;
    ctl.relax_v    = v3;
    ctl.relax_to   = to3;
    ctl.relax_from = cur;
    ctl.relax_cand = cand3;
  end

  for (genvar g = 0; g < VERTEX_SLOTS; g++) begin : g_cell
    wspe_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (VIDX_W'(g)),
      .active  (VCNT_W'(g) < n_act),
      .ctl     (ctl),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .rec     (recs[g])
    );
  end

  assign rsel     = recs[k];
  assign res_load = (state == S_OUT) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      edge_count <= '0;
      inject     <= 1'b0;
      j          <= '0;
      k          <= '0;
    end else begin
      inject <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req_type)
              REQ_CLEAR: edge_count <= '0;
              REQ_ADD: begin
                if (!bad_end && !full) begin
                  edge_count <= edge_count + 1'b1;
                end
              end
              REQ_RUN: begin
                if (!bad_start) begin
                  start <= origin_vertex;
                  state <= S_INIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          inject <= 1'b1;
          state  <= S_SEARCH;
        end
        S_SEARCH: begin
          if (search_done) begin
            if (chain[VERTEX_SLOTS].found) begin
              cur      <= chain[VERTEX_SLOTS].idx;
              cur_dist <= chain[VERTEX_SLOTS].plen;
              j        <= '0;
              state    <= S_EDGE;
            end else begin
              k     <= '0;
              state <= S_OUT;
            end
          end
        end
        S_EDGE: begin
          if (issue) begin
            j <= j + 1'b1;
          end
          if (edge_done) begin
            inject <= 1'b1;
            state  <= S_SEARCH;
          end
        end
        S_OUT: begin
          if (res_load) begin
            k <= k + 1'b1;
            if ({1'b0, k} + 1'b1 == n_act) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (err_load || res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (err_load) begin
      vertex_index    <= '0;
      path_distance   <= '0;
      reachable       <= 1'b0;
      has_predecessor <= 1'b0;
      predecessor     <= '0;
      status          <= err_code;
      last            <= 1'b1;
    end else if (res_load) begin
      vertex_index    <= k;
      path_distance   <= rsel.reached ? rsel.plen : DIST_MAX;
      reachable       <= rsel.reached;
      has_predecessor <= rsel.pv;
      predecessor     <= rsel.pv ? rsel.prev : '0;
      status          <= ST_OK;
      last            <= ({1'b0, k} + 1'b1 == n_act);
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("input taken outside idle");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result without last");
  a_count: assert property (@(posedge clk) disable iff (rst)
    edge_count <= ECNT_W'(MAX_EDGES))
    else $error("edge count overflow");
  a_settle: assert property (@(posedge clk) disable iff (rst)
    ctl.settle_v |=> state == S_EDGE)
    else $error("settle without edge scan");

endmodule
